// ===== rtl/iiea_pkg.sv =====
`timescale 1ns / 1ps
// Package for the indexed insert/erase array: request codes, status codes,
// field widths and the shift control word broadcast to every cell.
// No dependencies.
package iiea_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 2;

    // Request kinds
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_ERASE  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Shift command for the cell row; at most one bit set
    typedef struct packed {
        logic ins;
        logic ers;
    } t_shift_ctl;

endpackage

// ===== rtl/iiea_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the array row: holds a word and takes its neighbor's
// word on a shift. Depends on iiea_pkg.
module iiea_cell import iiea_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_shift_ctl        i_ctl,
    input  logic [POS_W-1:0]  i_pos,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left,   // word of cell IDX-1
    input  logic [DATA_W-1:0] i_right,  // word of cell IDX+1
    output logic [DATA_W-1:0] o_word,
    output logic [DATA_W-1:0] o_rd      // own word when addressed, else zero
);

    logic [DATA_W-1:0] r_word;
    logic [DATA_W-1:0] n_word;
    logic              w_at;
    logic              w_above;

    assign w_at    = (IDX == int'(i_pos));
    assign w_above = (IDX > int'(i_pos));

    // Next word: shift up on insert, down on erase
    always_comb begin
        n_word = r_word;
        if (i_ctl.ins) begin
            if (w_above) begin
                n_word = i_left;
            end else if (w_at) begin
                n_word = i_value;
            end
        end else if (i_ctl.ers) begin
            if (w_above || w_at) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_rd   = w_at ? r_word : '0;

endmodule

// ===== rtl/indexed_insert_erase_array.sv =====
`timescale 1ns / 1ps
// Top level of the indexed insert/erase array: control, element count and
// result register around a row of iiea_cell. Depends on iiea_pkg, iiea_cell.
//
// An ordered list of up to DEPTH signed 32-bit words. Each request item
// (mode on i_s_tuser) inserts, erases or reads at a position, or clears the
// list, and yields exactly one result item in the cycle after acceptance. All
// cells shift in parallel from their neighbor in the cycle a request is
// accepted, so the block takes one item every cycle; the only stall comes
// from the result register when the downstream side holds i_m_tready low.
// Cells below the count hold list words; cells at and above it hold stale words.
module indexed_insert_erase_array import iiea_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // [6:0] position, [38:7] value, [39] zero
    input  logic [1:0]  i_s_tuser,  // [1:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata   // [31:0] read_data, [33:32] status,
                                    // [40:34] count, [41] empty_res, rest zero
);

    localparam int FW   = $clog2(DEPTH + 1);
    localparam int CMPW = (FW > POS_W) ? FW : POS_W;

    // Input fields
    logic              w_accept;
    t_mode             w_mode;
    logic [POS_W-1:0]  w_pos;
    logic [DATA_W-1:0] w_value;
    logic [CMPW-1:0]   w_pos_x;
    logic [CMPW-1:0]   w_fill_x;

    // Control and state
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     n_fill;
    logic [STAT_W-1:0] w_status;
    t_shift_ctl        w_ctl;
    logic [DATA_W-1:0] w_words [DEPTH];
    logic [DATA_W-1:0] w_rds   [DEPTH];
    logic [DATA_W-1:0] w_rd_or;

    // Result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_rd;
    logic [STAT_W-1:0] r_status;
    logic [CNT_W-1:0]  r_count;
    logic              r_empty;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_mode     = t_mode'(i_s_tuser);
    assign w_pos      = i_s_tdata[6:0];
    assign w_value    = i_s_tdata[38:7];
    assign w_pos_x    = CMPW'(w_pos);
    assign w_fill_x   = CMPW'(r_fill);

    // Request decode: status, new count and shift command
    always_comb begin
        w_status = ST_OK;
        n_fill   = r_fill;
        w_ctl    = '0;
        unique case (w_mode)
            MODE_INSERT: begin
                if (w_pos_x > w_fill_x) begin
                    w_status = ST_RANGE;
                end else if (w_fill_x == CMPW'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_accept;
                    n_fill    = r_fill + FW'(1);
                end
            end
            MODE_ERASE: begin
                if (w_pos_x >= w_fill_x) begin
                    w_status = ST_RANGE;
                end else begin
                    w_ctl.ers = w_accept;
                    n_fill    = r_fill - FW'(1);
                end
            end
            MODE_READ: begin
                if (w_pos_x >= w_fill_x) begin
                    w_status = ST_RANGE;
                end
            end
            MODE_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_words[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_words[g];
        end else begin : g_mid_r
            assign w_right = w_words[g+1];
        end
        iiea_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_words[g]),
            .o_rd    (w_rds[g])
        );
    end

    // Read select: only the addressed cell drives a nonzero word
    always_comb begin
        w_rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rd_or = w_rd_or | w_rds[i];
        end
    end

    // Count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (w_accept) begin
            r_fill <= n_fill;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd     <= (w_mode == MODE_READ && w_status == ST_OK) ? w_rd_or : '0;
            r_status <= w_status;
            r_count  <= CNT_W'(n_fill);
            r_empty  <= (n_fill == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_empty, r_count, r_status, r_rd};

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("element count above capacity");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (DEPTH < 128)) |-> (r_empty == (r_count == '0)))
        else $error("empty flag disagrees with count");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == MODE_CLEAR) |=> (r_fill == '0 && r_status == ST_OK))
        else $error("clear did not empty the list");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == MODE_INSERT && r_fill == FW'(DEPTH))
        |=> (r_status != ST_OK && r_fill == FW'(DEPTH)))
        else $error("insert accepted into a full list");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for indexed_insert_erase_array: directed and random request items
// checked against a shadow copy of the list kept in a small scoreboard class.
// Depends on iiea_pkg and indexed_insert_erase_array.
module tb;
    import iiea_pkg::*;

    localparam int DEPTH      = 64;
    localparam int HOLD_LEN   = 300;
    localparam int STALL_MAX  = 5000;
    localparam int PHASE_LEN  = 125;
    localparam int NUM_PHASES = 8;

    // Bias of the random request mix
    typedef enum int { MIX_GROW, MIX_CHURN, MIX_SHRINK } t_mix;

    // One expected result item
    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic              empty_res;
    } t_list_result;

    // Shadow of the list contents and the queue of results still owed
    class list_tracker;
        logic [DATA_W-1:0] cells [DEPTH];
        int unsigned       fill;
        t_list_result      owed_results [$];
        int unsigned       failures;

        function new();
            fill     = 0;
            failures = 0;
        endfunction

        // Apply one accepted request and queue the result it should give
        function void apply_request(t_mode mode, logic [POS_W-1:0] pos,
                                    logic [DATA_W-1:0] val);
            t_list_result r;
            int unsigned  i;
            r.read_data = '0;
            r.status    = ST_OK;
            case (mode)
                MODE_INSERT: begin
                    if (pos > fill) begin
                        r.status = ST_RANGE;
                    end else if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        for (i = fill; i > pos; i--)
                            cells[i] = cells[i-1];
                        cells[pos] = val;
                        fill++;
                    end
                end
                MODE_ERASE: begin
                    if (pos >= fill) begin
                        r.status = ST_RANGE;
                    end else begin
                        for (i = pos; i + 1 < fill; i++)
                            cells[i] = cells[i+1];
                        fill--;
                    end
                end
                MODE_READ: begin
                    if (pos >= fill)
                        r.status = ST_RANGE;
                    else
                        r.read_data = cells[pos];
                end
                default: begin
                    fill = 0;
                end
            endcase
            r.count     = CNT_W'(fill);
            r.empty_res = (fill == 0);
            owed_results.insert(owed_results.size(), r);
        endfunction

        // Compare one result item with the oldest one owed
        function void match_result(logic [47:0] word);
            t_list_result want;
            if (owed_results.size() == 0) begin
                $error("unexpected result item %h with no request pending", word);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (word[31:0] !== want.read_data) begin
                $error("read_data: expected %0d, got %0d",
                       $signed(want.read_data), $signed(word[31:0]));
                failures++;
            end
            if (word[33:32] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, word[33:32]);
                failures++;
            end
            if (word[40:34] !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, word[40:34]);
                failures++;
            end
            if (word[41] !== want.empty_res) begin
                $error("empty_res: expected %0d, got %0d", want.empty_res, word[41]);
                failures++;
            end
            if (word[47:42] !== 6'd0) begin
                $error("padding: expected 0, got %h", word[47:42]);
                failures++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [39:0]        i_s_tdata;  // [6:0] position, [38:7] value, [39] zero
    logic [1:0]         i_s_tuser;  // [1:0] mode
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [47:0]        o_m_tdata;  // [31:0] read_data, [33:32] status,
                                    // [40:34] count, [41] empty_res

    list_tracker        list_sb;
    int                 tx_idle_pct;
    int                 rx_stall_pct;
    bit                 hold_request;
    int                 hold_left;
    int                 quiet_cycles;

    indexed_insert_erase_array #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Downstream side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_LEN;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            list_sb.match_result(o_m_tdata);
    end

    // Watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one request item and wait until it is taken
    task automatic send_request(t_mode mode, logic [POS_W-1:0] pos,
                                logic [DATA_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, val, pos};
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        list_sb.apply_request(mode, pos, val);
        @(negedge i_clk);
    endtask

    // Random word, with the extremes now and then
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One random request shaped by the mix; mostly in-range positions
    task automatic send_random(t_mix mix);
        int                r;
        int unsigned       cnt;
        t_mode             mode;
        logic [POS_W-1:0]  pos;
        r   = $urandom_range(99);
        cnt = list_sb.fill;
        case (mix)
            MIX_GROW:
                mode = (r < 70) ? MODE_INSERT : (r < 80) ? MODE_ERASE :
                       (r < 99) ? MODE_READ : MODE_CLEAR;
            MIX_SHRINK:
                mode = (r < 15) ? MODE_INSERT : (r < 70) ? MODE_ERASE :
                       (r < 98) ? MODE_READ : MODE_CLEAR;
            default:
                mode = (r < 35) ? MODE_INSERT : (r < 65) ? MODE_ERASE :
                       (r < 97) ? MODE_READ : MODE_CLEAR;
        endcase
        if ($urandom_range(9) < 2) begin
            pos = POS_W'($urandom_range(DEPTH, 0));
        end else if (mode == MODE_INSERT) begin
            case ($urandom_range(3))
                0:       pos = '0;
                1:       pos = POS_W'(cnt);
                default: pos = POS_W'($urandom_range(cnt, 0));
            endcase
        end else begin
            pos = (cnt == 0) ? '0 : POS_W'($urandom_range(cnt - 1, 0));
        end
        send_request(mode, pos, pick_word());
    endtask

    initial begin
        t_mix mix;
        list_sb      = new();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = MODE_READ;
        i_m_tready   = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty list, ends of the list, middle moves, bad indexes
        send_request(MODE_READ,   7'd0,  32'h1234_5678);
        send_request(MODE_ERASE,  7'd0,  32'h0);
        send_request(MODE_INSERT, 7'd1,  32'hdead_beef);
        send_request(MODE_CLEAR,  7'd0,  32'h0);
        send_request(MODE_INSERT, 7'd0,  32'h8000_0000);
        send_request(MODE_INSERT, 7'd1,  32'h7fff_ffff);
        send_request(MODE_INSERT, 7'd0,  32'h0000_0000);
        send_request(MODE_INSERT, 7'd1,  32'hffff_ffff);
        send_request(MODE_READ,   7'd0,  32'h0);
        send_request(MODE_READ,   7'd1,  32'h0);
        send_request(MODE_READ,   7'd2,  32'h0);
        send_request(MODE_READ,   7'd3,  32'h0);
        send_request(MODE_READ,   7'd4,  32'h0);
        send_request(MODE_READ,   7'd64, 32'hffff_ffff);
        send_request(MODE_ERASE,  7'd1,  32'h0);
        send_request(MODE_ERASE,  7'd2,  32'h0);
        send_request(MODE_ERASE,  7'd0,  32'h0);
        send_request(MODE_INSERT, 7'd64, 32'h5555_aaaa);
        send_request(MODE_ERASE,  7'd64, 32'h0);
        send_request(MODE_READ,   7'd0,  32'h0);
        send_request(MODE_CLEAR,  7'd64, 32'hffff_ffff);
        send_request(MODE_READ,   7'd0,  32'h0);

        // Random phases: idling pattern rotates, mix grows, churns and shrinks
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
                default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            case (ph)
                0, 2, 5: mix = MIX_GROW;
                3, 6:    mix = MIX_SHRINK;
                default: mix = MIX_CHURN;
            endcase
            // Long downstream hold-off while requests keep coming
            if (ph == 4)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++)
                send_random(mix);
        end
        i_s_tvalid <= 1'b0;

        // Drain the results still owed
        while (list_sb.owed_results.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (list_sb.failures == 0 && list_sb.owed_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/iiea_pkg.sv
rtl/iiea_cell.sv
rtl/indexed_insert_erase_array.sv
tb/tb.sv
